// ----- rtl/pfp_pkg.sv -----
// Shared types and constants for the picture block field parser.
// No dependencies; every other file in rtl/ imports this package.
package pfp_pkg;

    // One input beat: a block byte and its last-byte flag
    typedef struct packed {
        logic [7:0] blob_byte;
        logic       end_of_blob;
    } in_item_t;

    // One result beat
    typedef struct packed {
        logic [3:0]  item_kind;
        logic [31:0] item_value;
        logic        block_final;
        logic        block_status;
    } out_item_t;

    // Input register contents as seen by the parser core
    typedef struct packed {
        logic     vld;
        in_item_t item;
    } in_beat_t;

    // Result handed from the core to the output register
    typedef struct packed {
        logic      load;
        out_item_t item;
    } res_beat_t;

    // Parse phases, one-hot
    typedef enum logic [11:0] {
        PH_TYPE     = 12'b0000_0000_0001,
        PH_MIME_LEN = 12'b0000_0000_0010,
        PH_MIME     = 12'b0000_0000_0100,
        PH_DESC_LEN = 12'b0000_0000_1000,
        PH_DESC     = 12'b0000_0001_0000,
        PH_WIDTH    = 12'b0000_0010_0000,
        PH_HEIGHT   = 12'b0000_0100_0000,
        PH_DEPTH    = 12'b0000_1000_0000,
        PH_COLOURS  = 12'b0001_0000_0000,
        PH_PAY_LEN  = 12'b0010_0000_0000,
        PH_PAYLOAD  = 12'b0100_0000_0000,
        PH_DONE     = 12'b1000_0000_0000
    } phase_t;

    // Item kind codes
    localparam logic [3:0] KIND_NONE     = 4'd0;
    localparam logic [3:0] KIND_TYPE     = 4'd1;
    localparam logic [3:0] KIND_MIME     = 4'd2;
    localparam logic [3:0] KIND_DESC     = 4'd3;
    localparam logic [3:0] KIND_WIDTH    = 4'd4;
    localparam logic [3:0] KIND_HEIGHT   = 4'd5;
    localparam logic [3:0] KIND_DEPTH    = 4'd6;
    localparam logic [3:0] KIND_COLOURS  = 4'd7;
    localparam logic [3:0] KIND_PAYLOAD  = 4'd8;
    localparam logic [3:0] KIND_URI      = 4'd9;
    localparam logic [3:0] KIND_MIME_LEN = 4'd10;
    localparam logic [3:0] KIND_DESC_LEN = 4'd11;
    localparam logic [3:0] KIND_PAY_LEN  = 4'd12;

    // Block status codes
    localparam logic STATUS_COMPLETE  = 1'b0;
    localparam logic STATUS_TRUNCATED = 1'b1;

    // URI marker match progress: 0..3 bytes matched, or failed
    localparam logic [2:0] MATCH_NONE   = 3'd0;
    localparam logic [2:0] MATCH_FULL   = 3'd3;
    localparam logic [2:0] MATCH_FAILED = 3'd4;
    localparam logic [2:0] URI_MARK_LEN = 3'd3;

    // Last byte position of a 32-bit big-endian field
    localparam logic [1:0] FIELD_LAST_BYTE = 2'd3;

    // Bytes of the URI marker "-->"
    function automatic logic [7:0] uri_mark_byte(input logic [1:0] pos);
        logic [7:0] b;
        case (pos)
            2'd0:    b = 8'h2D;
            2'd1:    b = 8'h2D;
            2'd2:    b = 8'h3E;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ----- rtl/pfp_in_stage.sv -----
// Input register for the picture block field parser.
// Depends on pfp_pkg for the beat types.
module pfp_in_stage
    import pfp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     byte_valid,
    output logic     byte_stall,
    input  in_item_t byte_data,
    input  logic     take,
    output in_beat_t beat
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    logic     accept;

    // Hold off the sender only while the held beat cannot move on
    assign byte_stall = valid_reg && !take;
    assign accept     = byte_valid && !byte_stall;

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= byte_data;
        end
    end

    assign beat.vld  = valid_reg;
    assign beat.item = item_reg;

endmodule

// ----- rtl/pfp_field_core.sv -----
// Parser state and per-byte next-state logic for the picture block parser.
// Depends on pfp_pkg for beat types, phase codes and item kinds.
module pfp_field_core
    import pfp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  in_beat_t  beat,
    input  logic      res_ready,
    output logic      take,
    output res_beat_t res
);

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [1:0]  idx_reg;
    logic [1:0]  idx_next;
    logic [31:0] acc_reg;
    logic [31:0] acc_next;
    logic [31:0] rem_reg;
    logic [31:0] rem_next;
    logic [2:0]  match_reg;
    logic [2:0]  match_next;

    logic [7:0]  b;
    logic        fin;
    logic [31:0] acc_shift;
    logic        field_done;
    logic        rem_last;
    logic [3:0]  kind;
    logic [31:0] val;
    logic        status;
    phase_t      phase_step;
    logic [1:0]  idx_step;
    logic [31:0] acc_step;
    logic [31:0] rem_step;
    logic [2:0]  match_step;

    assign take      = beat.vld && res_ready;
    assign b         = beat.item.blob_byte;
    assign fin       = beat.item.end_of_blob;
    assign acc_shift = {acc_reg[23:0], b};
    assign field_done = (idx_reg == FIELD_LAST_BYTE);
    assign rem_last  = (rem_reg == 32'd1);

    // Per-byte parse step
    always_comb
    begin
        phase_step = phase_reg;
        idx_step   = idx_reg;
        acc_step   = acc_reg;
        rem_step   = rem_reg;
        match_step = match_reg;
        kind       = KIND_NONE;
        val        = 32'd0;
        case (phase_reg)
            PH_TYPE, PH_MIME_LEN, PH_DESC_LEN, PH_WIDTH,
            PH_HEIGHT, PH_DEPTH, PH_COLOURS, PH_PAY_LEN:
            begin
                if (field_done)
                begin
                    idx_step = 2'd0;
                    acc_step = 32'd0;
                    val      = acc_shift;
                    case (phase_reg)
                        PH_TYPE:
                        begin
                            kind       = KIND_TYPE;
                            phase_step = PH_MIME_LEN;
                        end
                        PH_MIME_LEN:
                        begin
                            kind       = KIND_MIME_LEN;
                            rem_step   = acc_shift;
                            match_step = (acc_shift == {29'd0, URI_MARK_LEN}) ?
                                         MATCH_NONE : MATCH_FAILED;
                            phase_step = (acc_shift != 32'd0) ? PH_MIME : PH_DESC_LEN;
                        end
                        PH_DESC_LEN:
                        begin
                            kind       = KIND_DESC_LEN;
                            rem_step   = acc_shift;
                            phase_step = (acc_shift != 32'd0) ? PH_DESC : PH_WIDTH;
                        end
                        PH_WIDTH:
                        begin
                            kind       = KIND_WIDTH;
                            phase_step = PH_HEIGHT;
                        end
                        PH_HEIGHT:
                        begin
                            kind       = KIND_HEIGHT;
                            phase_step = PH_DEPTH;
                        end
                        PH_DEPTH:
                        begin
                            kind       = KIND_DEPTH;
                            phase_step = PH_COLOURS;
                        end
                        PH_COLOURS:
                        begin
                            kind       = KIND_COLOURS;
                            phase_step = PH_PAY_LEN;
                        end
                        default:
                        begin
                            kind       = KIND_PAY_LEN;
                            rem_step   = acc_shift;
                            phase_step = (acc_shift != 32'd0) ? PH_PAYLOAD : PH_DONE;
                        end
                    endcase
                end
                else
                begin
                    idx_step = idx_reg + 2'd1;
                    acc_step = acc_shift;
                end
            end
            PH_MIME:
            begin
                kind     = KIND_MIME;
                val      = {24'd0, b};
                rem_step = rem_reg - 32'd1;
                if (match_reg < MATCH_FULL && b == uri_mark_byte(match_reg[1:0]))
                begin
                    match_step = match_reg + 3'd1;
                end
                else
                begin
                    match_step = MATCH_FAILED;
                end
                if (rem_last)
                begin
                    phase_step = PH_DESC_LEN;
                end
            end
            PH_DESC:
            begin
                kind     = KIND_DESC;
                val      = {24'd0, b};
                rem_step = rem_reg - 32'd1;
                if (rem_last)
                begin
                    phase_step = PH_WIDTH;
                end
            end
            PH_PAYLOAD:
            begin
                kind     = (match_reg == MATCH_FULL) ? KIND_URI : KIND_PAYLOAD;
                val      = {24'd0, b};
                rem_step = rem_reg - 32'd1;
                if (rem_last)
                begin
                    phase_step = PH_DONE;
                end
            end
            default:
            begin
                // finished: trailing bytes are dropped
            end
        endcase
    end

    // Last byte closes the block and restarts parsing
    assign status = (phase_step == PH_DONE) ? STATUS_COMPLETE : STATUS_TRUNCATED;

    always_comb
    begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        match_next = match_reg;
        if (take)
        begin
            if (fin)
            begin
                phase_next = PH_TYPE;
                idx_next   = 2'd0;
                acc_next   = 32'd0;
                rem_next   = 32'd0;
                match_next = MATCH_NONE;
            end
            else
            begin
                phase_next = phase_step;
                idx_next   = idx_step;
                acc_next   = acc_step;
                rem_next   = rem_step;
                match_next = match_step;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TYPE;
            idx_reg   <= 2'd0;
            acc_reg   <= 32'd0;
            rem_reg   <= 32'd0;
            match_reg <= MATCH_NONE;
        end
        else
        begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            acc_reg   <= acc_next;
            rem_reg   <= rem_next;
            match_reg <= match_next;
        end
    end

    // Result beat: an item, or the closing beat of a block
    assign res.load              = take && (fin || kind != KIND_NONE);
    assign res.item.item_kind    = kind;
    assign res.item.item_value   = val;
    assign res.item.block_final  = fin;
    assign res.item.block_status = fin ? status : STATUS_COMPLETE;

    // A byte-counted section is never entered with nothing left to count
    a_rem_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_MIME || phase_reg == PH_DESC || phase_reg == PH_PAYLOAD)
        |-> rem_reg != 32'd0)
        else $error("byte section active with zero bytes remaining");

    // Partial field bytes only exist inside a field phase
    a_idx_in_field: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_MIME || phase_reg == PH_DESC ||
         phase_reg == PH_PAYLOAD || phase_reg == PH_DONE)
        |-> idx_reg == 2'd0)
        else $error("field byte index left over outside a field");

    // Accumulator is empty at the start of each field
    a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg == 2'd0 |-> acc_reg == 32'd0)
        else $error("field accumulator not cleared between fields");

    // The last byte of a block returns the parser to its start
    a_fin_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (take && fin) |=> (phase_reg == PH_TYPE && idx_reg == 2'd0 &&
                           match_reg == MATCH_NONE))
        else $error("parser did not restart after last byte");

endmodule

// ----- rtl/pfp_out_stage.sv -----
// Result register for the picture block field parser.
// Depends on pfp_pkg for the result types.
module pfp_out_stage
    import pfp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  res_beat_t res,
    output logic      res_ready,
    output logic      result_valid,
    input  logic      result_stall,
    output out_item_t result_data
);

    logic      valid_reg;
    logic      valid_next;
    out_item_t item_reg;

    // Register is free when empty or being drained this cycle
    assign res_ready = !valid_reg || !result_stall;

    always_comb
    begin
        if (res_ready)
        begin
            valid_next = res.load;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res.load)
        begin
            item_reg <= res.item;
        end
    end

    assign result_valid = valid_reg;
    assign result_data  = item_reg;

endmodule

// ----- rtl/picture_block_field_parser.sv -----
// Picture metadata block parser: takes one block byte per beat and yields
// at most one result beat per byte. One byte is accepted every cycle while
// the result side does not stall; each byte is held in the input register
// and its result is registered in the result register, with the parse step
// itself (a 32-bit shift, a length count-down and a phase update) done
// between the input and result registers.
// A stall on the result side holds the result register and,
// through it, raises byte_stall in the same cycle once the input register
// is also occupied. Bytes that produce no item leave no result beat; the
// last byte of a block always gives one, carrying block_final and the
// complete or truncated status, and the next byte starts a new block.
// Depends on pfp_pkg, pfp_in_stage, pfp_field_core and pfp_out_stage.
module picture_block_field_parser
    import pfp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      byte_valid,
    output logic      byte_stall,
    input  in_item_t  byte_data,
    output logic      result_valid,
    input  logic      result_stall,
    output out_item_t result_data
);

    in_beat_t  beat;
    res_beat_t res;
    logic      take;
    logic      res_ready;

    pfp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_data  (byte_data),
        .take       (take),
        .beat       (beat)
    );

    pfp_field_core u_field_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .beat      (beat),
        .res_ready (res_ready),
        .take      (take),
        .res       (res)
    );

    pfp_out_stage u_out_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .res          (res),
        .res_ready    (res_ready),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

endmodule

// ----- verif/tb_picture_block_field_parser.sv -----
// Self-checking testbench for picture_block_field_parser: directed blocks
// from a table, then random well-formed, cut-short and noise blocks.
// Depends on pfp_pkg and the parser RTL; results are checked by an in-bench parser.
`timescale 1ns / 100ps

module tb_picture_block_field_parser;
    import pfp_pkg::*;

    localparam int          SETTLE_CYCLES = 8;
    localparam int          HOLD_CYCLES   = 300;
    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int          RANDOM_BEATS  = 1166;
    localparam int          DIR_ROWS      = 29;
    localparam logic [23:0] URI_MARK      = 24'h2D2D3E;   // "-->"

    localparam out_item_t NO_RES = '0;

    // One directed row: a single byte, or a 32-bit field sent as four bytes
    typedef struct packed {
        logic        word;
        logic [31:0] value;
        logic        last;
        logic        typed;
        out_item_t   result;
    } dir_row_t;

    logic      clk;
    logic      rst_n;
    logic      byte_valid;
    logic      byte_stall;
    in_item_t  byte_data;
    logic      result_valid;
    logic      result_stall;
    out_item_t result_data;

    // Parser state mirrored in the bench
    phase_t      ph;
    logic [1:0]  byte_idx;
    logic [31:0] acc;
    logic [31:0] remaining;
    logic [2:0]  mark_prog;

    out_item_t   parsed_items_q[$];
    dir_row_t    dir_rows [DIR_ROWS];
    int          mismatch_count;
    int          random_beats;
    int          idle_pct;
    int          stall_pct;
    bit          hold_request;
    int unsigned cycle_count;

    picture_block_field_parser dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .byte_data    (byte_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic void reset_parse_state();
        ph        = PH_TYPE;
        byte_idx  = '0;
        acc       = '0;
        remaining = '0;
        mark_prog = MATCH_NONE;
    endfunction

    // Parse one block byte; returns 1 when the byte yields a result beat
    function automatic bit parse_picture_byte(input in_item_t beat, output out_item_t res);
        logic [3:0]  kind;
        logic [31:0] val;
        kind = KIND_NONE;
        val  = '0;
        res  = '0;
        case (ph)
            PH_MIME:
            begin
                kind = KIND_MIME;
                val  = {24'd0, beat.blob_byte};
                if (mark_prog < URI_MARK_LEN &&
                    beat.blob_byte == URI_MARK[8 * (2 - int'(mark_prog)) +: 8])
                    mark_prog = mark_prog + 1'b1;
                else
                    mark_prog = MATCH_FAILED;
                remaining = remaining - 1;
                if (remaining == 0)
                    ph = PH_DESC_LEN;
            end
            PH_DESC:
            begin
                kind      = KIND_DESC;
                val       = {24'd0, beat.blob_byte};
                remaining = remaining - 1;
                if (remaining == 0)
                    ph = PH_WIDTH;
            end
            PH_PAYLOAD:
            begin
                kind      = (mark_prog == MATCH_FULL) ? KIND_URI : KIND_PAYLOAD;
                val       = {24'd0, beat.blob_byte};
                remaining = remaining - 1;
                if (remaining == 0)
                    ph = PH_DONE;
            end
            PH_DONE: ;  // trailing bytes are dropped
            default:
            begin
                // big-endian 32-bit field
                acc = {acc[23:0], beat.blob_byte};
                if (byte_idx == FIELD_LAST_BYTE)
                begin
                    val      = acc;
                    acc      = '0;
                    byte_idx = '0;
                    case (ph)
                        PH_TYPE:
                        begin
                            kind = KIND_TYPE;
                            ph   = PH_MIME_LEN;
                        end
                        PH_MIME_LEN:
                        begin
                            kind      = KIND_MIME_LEN;
                            remaining = val;
                            mark_prog = (val == {29'd0, URI_MARK_LEN}) ? MATCH_NONE
                                                                       : MATCH_FAILED;
                            ph        = (val != 0) ? PH_MIME : PH_DESC_LEN;
                        end
                        PH_DESC_LEN:
                        begin
                            kind      = KIND_DESC_LEN;
                            remaining = val;
                            ph        = (val != 0) ? PH_DESC : PH_WIDTH;
                        end
                        PH_WIDTH:
                        begin
                            kind = KIND_WIDTH;
                            ph   = PH_HEIGHT;
                        end
                        PH_HEIGHT:
                        begin
                            kind = KIND_HEIGHT;
                            ph   = PH_DEPTH;
                        end
                        PH_DEPTH:
                        begin
                            kind = KIND_DEPTH;
                            ph   = PH_COLOURS;
                        end
                        PH_COLOURS:
                        begin
                            kind = KIND_COLOURS;
                            ph   = PH_PAY_LEN;
                        end
                        default:
                        begin
                            kind      = KIND_PAY_LEN;
                            remaining = val;
                            ph        = (val != 0) ? PH_PAYLOAD : PH_DONE;
                        end
                    endcase
                end
                else
                begin
                    byte_idx = byte_idx + 1'b1;
                end
            end
        endcase

        // last byte closes the block and restarts the parse
        if (beat.end_of_blob)
        begin
            res.block_final  = 1'b1;
            res.block_status = (ph == PH_DONE) ? STATUS_COMPLETE : STATUS_TRUNCATED;
            reset_parse_state();
        end
        else if (kind == KIND_NONE)
        begin
            return 1'b0;
        end
        res.item_kind  = kind;
        res.item_value = val;
        return 1'b1;
    endfunction

    function automatic void note_mismatch(input string what, input out_item_t want,
                                          input out_item_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $write("%s: expected kind %0d value %h final %b status %b, ",
                   what, want.item_kind, want.item_value, want.block_final,
                   want.block_status);
            $display("got kind %0d value %h final %b status %b",
                     got.item_kind, got.item_value, got.block_final, got.block_status);
        end
    endfunction

    // Offer one beat, with random idle cycles ahead of it, and wait until taken
    task automatic send_beat(input in_item_t beat, input bit use_typed,
                             input out_item_t typed_res);
        out_item_t res;
        bit        produced;
        while ($urandom_range(99) < idle_pct)
        begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_data  <= beat;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        produced = parse_picture_byte(beat, res);
        if (use_typed)
            parsed_items_q.push_back(typed_res);
        else if (produced)
            parsed_items_q.push_back(res);
    endtask

    // Stop offering and wait for every pending result, then let the pipe settle
    task automatic wait_results_drained();
        byte_valid <= 1'b0;
        while (parsed_items_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic push_word(ref logic [7:0] blk[$], input logic [31:0] w);
        for (int k = 3; k >= 0; k--)
            blk.push_back(w[8 * k +: 8]);
    endtask

    // Random blocks: mostly well formed, some cut short, some pure noise
    task automatic run_random_blocks(input int target);
        logic [7:0] blk[$];
        in_item_t   beat;
        int         mode;
        int         mime_len;
        int         desc_len;
        int         pay_len;
        int         tail;
        int         keep;
        bit         exact;
        while (random_beats < target)
        begin
            blk.delete();
            tail = 0;
            mode = $urandom_range(99);
            if (mode >= 88)
            begin
                repeat ($urandom_range(40, 1)) blk.push_back(8'($urandom));
            end
            else
            begin
                mime_len = ($urandom_range(2) == 0) ? 3 : $urandom_range(6);
                desc_len = $urandom_range(5);
                pay_len  = ($urandom_range(15) == 0) ? $urandom_range(40, 9)
                                                     : $urandom_range(8);
                exact    = (mime_len == 3) && ($urandom_range(9) < 6);
                push_word(blk, $urandom);
                push_word(blk, mime_len);
                // media type built around the marker, sometimes corrupted or zeroed
                for (int i = 0; i < mime_len; i++)
                begin
                    if (exact || $urandom_range(3) != 0)
                        blk.push_back(URI_MARK[8 * (2 - (i % 3)) +: 8]);
                    else if ($urandom_range(1) == 0)
                        blk.push_back(8'h00);
                    else
                        blk.push_back(8'($urandom));
                end
                push_word(blk, desc_len);
                repeat (desc_len) blk.push_back(8'($urandom));
                repeat (4) push_word(blk, $urandom);
                push_word(blk, pay_len);
                repeat (pay_len) blk.push_back(8'($urandom));
                if ($urandom_range(3) == 0)
                begin
                    tail = $urandom_range(3, 1);
                    repeat (tail) blk.push_back(8'($urandom));
                end
                if (mode >= 70)
                begin
                    keep = $urandom_range(blk.size() - 1, 1);
                    while (blk.size() > keep)
                        void'(blk.pop_back());
                    tail = 0;
                end
            end
            for (int i = 0; i < blk.size(); i++)
            begin
                beat.blob_byte   = blk[i];
                beat.end_of_blob = (i == blk.size() - 1);
                send_beat(beat, 1'b0, NO_RES);
            end
            random_beats += blk.size() - tail;
        end
    endtask

    // Result side: random stalls plus one long hold-off on request
    initial
    begin : result_sink
        int hold_left;
        hold_left    = 0;
        result_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                result_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                result_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // Compare each accepted result beat with the oldest pending one
    always @(posedge clk)
    begin : result_check
        out_item_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (parsed_items_q.size() == 0)
            begin
                note_mismatch("unexpected result beat", NO_RES, result_data);
            end
            else
            begin
                want = parsed_items_q.pop_front();
                if (result_data.item_kind    !== want.item_kind  ||
                    result_data.item_value   !== want.item_value ||
                    result_data.block_final  !== want.block_final ||
                    result_data.block_status !== want.block_status)
                    note_mismatch("result mismatch", want, result_data);
            end
        end
    end

    // Stimulus
    initial
    begin : stimulus
        in_item_t beat;
        int       n;
        mismatch_count = 0;
        random_beats   = 0;
        idle_pct       = 22;
        stall_pct      = 22;
        hold_request   = 1'b0;
        rst_n          = 1'b0;
        byte_valid     <= 1'b0;
        byte_data      <= '0;
        reset_parse_state();

        dir_rows = '{
            // lone last byte: nothing parsed, block cut short
            {1'b0, 32'h0000_00A5, 1'b1, 1'b1, KIND_NONE, 32'h0, 1'b1, STATUS_TRUNCATED},
            // type field ends the block
            {1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1, KIND_TYPE, 32'hFFFF_FFFF, 1'b1,
             STATUS_TRUNCATED},
            // full block with a "-->" media type: payload goes out as URI bytes
            {1'b1, 32'h0000_0000, 1'b0, 1'b1, KIND_TYPE, 32'h0, 1'b0, STATUS_COMPLETE},
            {1'b1, 32'h0000_0003, 1'b0, 1'b1, KIND_MIME_LEN, 32'h3, 1'b0, STATUS_COMPLETE},
            {1'b0, 32'h0000_002D, 1'b0, 1'b1, KIND_MIME, 32'h2D, 1'b0, STATUS_COMPLETE},
            {1'b0, 32'h0000_002D, 1'b0, 1'b0, NO_RES},
            {1'b0, 32'h0000_003E, 1'b0, 1'b0, NO_RES},
            // empty description is skipped
            {1'b1, 32'h0000_0000, 1'b0, 1'b1, KIND_DESC_LEN, 32'h0, 1'b0, STATUS_COMPLETE},
            {1'b1, 32'hFFFF_FFFF, 1'b0, 1'b1, KIND_WIDTH, 32'hFFFF_FFFF, 1'b0,
             STATUS_COMPLETE},
            {1'b1, 32'h8000_0001, 1'b0, 1'b0, NO_RES},
            {1'b1, 32'h0000_0018, 1'b0, 1'b0, NO_RES},
            {1'b1, 32'h0000_0000, 1'b0, 1'b1, KIND_COLOURS, 32'h0, 1'b0, STATUS_COMPLETE},
            {1'b1, 32'h0000_0002, 1'b0, 1'b1, KIND_PAY_LEN, 32'h2, 1'b0, STATUS_COMPLETE},
            {1'b0, 32'h0000_00FF, 1'b0, 1'b0, NO_RES},
            {1'b0, 32'h0000_0000, 1'b0, 1'b0, NO_RES},
            // bytes past the payload are dropped; last one closes complete
            {1'b0, 32'h0000_007F, 1'b0, 1'b0, NO_RES},
            {1'b0, 32'h0000_0080, 1'b1, 1'b1, KIND_NONE, 32'h0, 1'b1, STATUS_COMPLETE},
            // media type with a zero byte: plain payload, here of zero length
            {1'b1, 32'h0000_0001, 1'b0, 1'b0, NO_RES},
            {1'b1, 32'h0000_0003, 1'b0, 1'b0, NO_RES},
            {1'b0, 32'h0000_002D, 1'b0, 1'b0, NO_RES},
            {1'b0, 32'h0000_0000, 1'b0, 1'b0, NO_RES},
            {1'b0, 32'h0000_003E, 1'b0, 1'b0, NO_RES},
            {1'b1, 32'h0000_0001, 1'b0, 1'b0, NO_RES},
            {1'b0, 32'h0000_0041, 1'b0, 1'b0, NO_RES},
            {1'b1, 32'h7FFF_FFFF, 1'b0, 1'b0, NO_RES},
            {1'b1, 32'h0000_0000, 1'b0, 1'b0, NO_RES},
            {1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0, NO_RES},
            {1'b1, 32'h0000_0001, 1'b0, 1'b0, NO_RES},
            {1'b1, 32'h0000_0000, 1'b1, 1'b1, KIND_PAY_LEN, 32'h0, 1'b1, STATUS_COMPLETE}
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows; a word row goes out most significant byte first
        for (int r = 0; r < DIR_ROWS; r++)
        begin
            n = dir_rows[r].word ? 4 : 1;
            for (int k = n - 1; k >= 0; k--)
            begin
                beat.blob_byte   = dir_rows[r].value[8 * k +: 8];
                beat.end_of_blob = dir_rows[r].last && (k == 0);
                if (k == 0 && dir_rows[r].typed)
                    send_beat(beat, 1'b1, dir_rows[r].result);
                else
                    send_beat(beat, 1'b0, NO_RES);
            end
        end
        wait_results_drained();

        // Random traffic with a long hold-off on the result side
        run_random_blocks(400);
        hold_request = 1'b1;
        run_random_blocks(600);

        // Sender pauses until everything is out
        wait_results_drained();

        // Back-to-back stretch, no idling on either side
        idle_pct  = 0;
        stall_pct = 0;
        run_random_blocks(850);

        idle_pct  = 22;
        stall_pct = 22;
        run_random_blocks(RANDOM_BEATS);
        wait_results_drained();

        if (mismatch_count == 0 && parsed_items_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/pfp_pkg.sv
rtl/pfp_in_stage.sv
rtl/pfp_field_core.sv
rtl/pfp_out_stage.sv
rtl/picture_block_field_parser.sv
verif/tb_picture_block_field_parser.sv
